/* hdl/xcfr_pkg.sv */
// Shared types, constants and helper functions of the XOR checksum frame receiver.
`default_nettype none

package xcfr_pkg;

  localparam int MAX_FRAME   = 64;
  localparam int CNT_W       = $clog2(MAX_FRAME + 1);
  localparam int ADDR_W      = $clog2(MAX_FRAME);
  localparam int NUM_BANKS   = 2;
  localparam int RAM_AW      = ADDR_W + 1;
  localparam int RAM_DEPTH   = NUM_BANKS * (2 ** ADDR_W);
  localparam int QUEUE_DEPTH = NUM_BANKS;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int HIST_LEN    = 4;

  localparam logic [7:0] START_BYTE = 8'h24;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  localparam logic signed [8:0] HEX_ALPHA_OFS = 9'sd55;
  localparam logic signed [8:0] HEX_NUM_OFS   = 9'sd48;

  localparam int MIN_TRIMMED = 12;
  localparam int MIN_RAW     = MIN_TRIMMED + 2;
  localparam int PAY_START   = 10;
  localparam int PAY_TAIL    = 15;

  localparam int POS_DST_HI  = 1;
  localparam int POS_DST_LO  = 2;
  localparam int POS_SRC_HI  = 3;
  localparam int POS_SRC_LO  = 4;
  localparam int POS_CMD_HI  = 6;
  localparam int POS_CMD_MID = 7;
  localparam int POS_CMD_LO  = 8;

  typedef enum logic [1:0] {
    ST_GOOD      = 2'd0,
    ST_BAD_SUM   = 2'd1,
    ST_TOO_LONG  = 2'd2,
    ST_TOO_SHORT = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_SHOW
  } back_state_t;

  typedef struct packed {
    status_t            status;
    logic [15:0]        dest_pair;
    logic [15:0]        source_pair;
    logic [23:0]        command_code;
    logic [CNT_W-1:0]   npay;
    logic               bank;
  } frame_desc_t;

  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } ram_wr_t;

  function automatic logic signed [8:0] hex_val(input logic [7:0] d);
    logic signed [8:0] wide;
    wide = $signed({1'b0, d});
    if (d > DIGIT_NINE) begin
      return wide - HEX_ALPHA_OFS;
    end
    return wide - HEX_NUM_OFS;
  endfunction

endpackage

`default_nettype wire

/* hdl/xor_checksum_frame_receiver_top.sv */
// Top level of the XOR checksum frame receiver.
// The input channel takes one received byte per transaction (in_valid, in_stall, in_rx_byte).
// Bytes are dropped until a '$'; the frame then runs until a CR directly followed by an LF.
// The front part accepts a byte in every cycle while in_stall is low and writes it into one of two frame banks.
// When a frame ends, a descriptor with its status and header fields enters a two-entry queue.
// The back part turns each descriptor into results on the output channel, one per data byte
// of a good frame, or a single result for an empty good frame or an error.
// For a frame without data the back part goes from idle straight to showing its result; a frame
// with data first passes a read state, and so does each further data result, since the read of
// the frame memory is registered.
// in_stall rises while two finished frames still wait for their results, so a third frame
// cannot overwrite a bank that is still being read; otherwise input runs at one byte a cycle.
// When the receiver holds out_stall, the result and its fields stay unchanged until taken.
// After reset the block hunts for a '$' with an empty queue; the memory needs no clearing.
`default_nettype none

module xor_checksum_frame_receiver_top import xcfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_dest_pair,
  output logic [15:0] out_source_pair,
  output logic [23:0] out_command_code,
  output logic [7:0]  out_payload_byte,
  output logic        out_has_payload,
  output logic        out_last_of_frame
);

  logic              q_full;
  logic              q_empty;
  logic              byte_acc;
  ram_wr_t           ram_wr;
  logic              push;
  frame_desc_t       push_desc;
  logic              pop;
  frame_desc_t       head;
  logic [RAM_AW-1:0] rd_addr;
  logic [7:0]        rd_data;

  assign in_stall = q_full;
  assign byte_acc = in_valid && !q_full;

  xcfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_acc  (byte_acc),
    .rx_byte   (in_rx_byte),
    .ram_wr    (ram_wr),
    .push      (push),
    .push_desc (push_desc)
  );

  xcfr_ram #(
    .WIDTH (8),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  xcfr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  xcfr_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_empty),
    .head              (head),
    .pop               (pop),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .res_valid         (out_valid),
    .res_stall         (out_stall),
    .res_status        (out_status),
    .res_dest_pair     (out_dest_pair),
    .res_source_pair   (out_source_pair),
    .res_command_code  (out_command_code),
    .res_payload_byte  (out_payload_byte),
    .res_has_payload   (out_has_payload),
    .res_last_of_frame (out_last_of_frame)
  );

  a_bank_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_wr.en && !q_empty) |-> (ram_wr.addr[RAM_AW-1] != head.bank))
    else $error("Frame write hit the bank that is being read.");

  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_GOOD) |-> (out_last_of_frame && !out_has_payload))
    else $error("Error result is not a single final result.");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_has_payload) |-> out_last_of_frame)
    else $error("Result without data is not the final one.");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last_of_frame) |=> !out_valid)
    else $error("Result shown in the cycle after the final one was taken.");

endmodule

`default_nettype wire

/* hdl/xcfr_ram.sv */
// Generic single-write, single-read memory with registered read data.
`default_nettype none

module xcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

/* hdl/xcfr_front.sv */
// Front part: frame hunting, byte storage, header capture and frame classification.
`default_nettype none

module xcfr_front import xcfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        byte_acc,
  input  logic [7:0]  rx_byte,
  output ram_wr_t     ram_wr,
  output logic        push,
  output frame_desc_t push_desc
);

  logic             in_frame_r, in_frame_nxt;
  logic             cr_seen_r, cr_seen_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic [7:0]       hist_r [HIST_LEN];
  logic [7:0]       hist_nxt [HIST_LEN];
  logic [15:0]      dst_r, dst_nxt;
  logic [15:0]      src_r, src_nxt;
  logic [23:0]      cmd_r, cmd_nxt;

  logic              store_ok;
  logic              is_end;
  logic [CNT_W-1:0]  n_end;
  logic              ovf_end;
  logic [7:0]        calc;
  logic signed [8:0] hex_hi;
  logic signed [8:0] hex_lo;
  logic [12:0]       given;

  assign store_ok = count_r < CNT_W'(MAX_FRAME);
  assign is_end   = in_frame_r && cr_seen_r && (rx_byte == LF_BYTE);

  always_comb begin
    in_frame_nxt = in_frame_r;
    cr_seen_nxt  = cr_seen_r;
    count_nxt    = count_r;
    xor_nxt      = xor_r;
    ovf_nxt      = ovf_r;
    bank_nxt     = bank_r;
    hist_nxt     = hist_r;
    dst_nxt      = dst_r;
    src_nxt      = src_r;
    cmd_nxt      = cmd_r;
    ram_wr       = '0;
    push         = 1'b0;
    if (byte_acc) begin
      if (!in_frame_r) begin
        if (rx_byte == START_BYTE) begin
          in_frame_nxt = 1'b1;
          cr_seen_nxt  = 1'b0;
          count_nxt    = CNT_W'(1);
          xor_nxt      = '0;
          ovf_nxt      = 1'b0;
        end
      end else begin
        if (store_ok) begin
          ram_wr.en   = 1'b1;
          ram_wr.addr = {bank_r, count_r[ADDR_W-1:0]};
          ram_wr.data = rx_byte;
          count_nxt   = count_r + CNT_W'(1);
          xor_nxt     = xor_r ^ rx_byte;
          hist_nxt[0] = rx_byte;
          for (int i = 1; i < HIST_LEN; i++) begin
            hist_nxt[i] = hist_r[i-1];
          end
          case (count_r)
            CNT_W'(POS_DST_HI):  dst_nxt[15:8]  = rx_byte;
            CNT_W'(POS_DST_LO):  dst_nxt[7:0]   = rx_byte;
            CNT_W'(POS_SRC_HI):  src_nxt[15:8]  = rx_byte;
            CNT_W'(POS_SRC_LO):  src_nxt[7:0]   = rx_byte;
            CNT_W'(POS_CMD_HI):  cmd_nxt[23:16] = rx_byte;
            CNT_W'(POS_CMD_MID): cmd_nxt[15:8]  = rx_byte;
            CNT_W'(POS_CMD_LO):  cmd_nxt[7:0]   = rx_byte;
            default: ;
          endcase
        end else begin
          ovf_nxt = 1'b1;
        end
        cr_seen_nxt = (rx_byte == CR_BYTE);
        if (is_end) begin
          push         = 1'b1;
          in_frame_nxt = 1'b0;
          cr_seen_nxt  = 1'b0;
          count_nxt    = '0;
          xor_nxt      = '0;
          ovf_nxt      = 1'b0;
          bank_nxt     = ~bank_r;
        end
      end
    end
  end

  // The terminating LF is the byte arriving now, so the history holds the CR, both hex digits
  // and the separator. XORing those out of the running sum leaves the checksummed span.
  assign n_end   = store_ok ? count_r + CNT_W'(1) : count_r;
  assign ovf_end = ovf_r | ~store_ok;
  assign calc    = xor_r ^ hist_r[0] ^ hist_r[1] ^ hist_r[2] ^ hist_r[3];
  assign hex_hi  = hex_val(hist_r[2]);
  assign hex_lo  = hex_val(hist_r[1]);
  assign given   = {hex_hi, 4'b0000} + {{4{hex_lo[8]}}, hex_lo};

  always_comb begin
    push_desc      = '0;
    push_desc.bank = bank_r;
    if (ovf_end) begin
      push_desc.status = ST_TOO_LONG;
    end else if (n_end < CNT_W'(MIN_RAW)) begin
      push_desc.status = ST_TOO_SHORT;
    end else if (given != {5'b00000, calc}) begin
      push_desc.status = ST_BAD_SUM;
    end else begin
      push_desc.status       = ST_GOOD;
      push_desc.dest_pair    = dst_r;
      push_desc.source_pair  = src_r;
      push_desc.command_code = cmd_r;
      if (n_end > CNT_W'(PAY_TAIL)) begin
        push_desc.npay = n_end - CNT_W'(PAY_TAIL);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      cr_seen_r  <= 1'b0;
      count_r    <= '0;
      xor_r      <= '0;
      ovf_r      <= 1'b0;
      bank_r     <= 1'b0;
    end else begin
      in_frame_r <= in_frame_nxt;
      cr_seen_r  <= cr_seen_nxt;
      count_r    <= count_nxt;
      xor_r      <= xor_nxt;
      ovf_r      <= ovf_nxt;
      bank_r     <= bank_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hist_r <= hist_nxt;
    dst_r  <= dst_nxt;
    src_r  <= src_nxt;
    cmd_r  <= cmd_nxt;
  end

endmodule

`default_nettype wire

/* hdl/xcfr_queue.sv */
// Short queue of frame descriptors between the front and back parts.
`default_nettype none

module xcfr_queue import xcfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  frame_desc_t push_desc,
  input  logic        pop,
  output frame_desc_t head,
  output logic        full,
  output logic        empty
);

  frame_desc_t       entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == QCNT_W'(QUEUE_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

/* hdl/xcfr_back.sv */
// Back part: walks the stored data bytes of each queued frame and presents the results.
`default_nettype none

module xcfr_back import xcfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  frame_desc_t       head,
  output logic              pop,
  output logic [RAM_AW-1:0] rd_addr,
  input  logic [7:0]        rd_data,
  output logic              res_valid,
  input  logic              res_stall,
  output logic [1:0]        res_status,
  output logic [15:0]       res_dest_pair,
  output logic [15:0]       res_source_pair,
  output logic [23:0]       res_command_code,
  output logic [7:0]        res_payload_byte,
  output logic              res_has_payload,
  output logic              res_last_of_frame
);

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [7:0]       pay_r;
  logic             has_r;
  logic             last_r;
  logic             load_none;
  logic             load_pay;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_empty) begin
          state_nxt = (head.npay == '0) ? BK_SHOW : BK_READ;
        end
      end
      BK_READ: state_nxt = BK_SHOW;
      BK_SHOW: begin
        if (!res_stall) begin
          state_nxt = last_r ? BK_IDLE : BK_READ;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    load_none = 1'b0;
    load_pay  = 1'b0;
    pop       = 1'b0;
    idx_nxt   = idx_r;
    unique case (state_r)
      BK_IDLE: begin
        idx_nxt   = '0;
        load_none = !q_empty && (head.npay == '0);
      end
      BK_READ: load_pay = 1'b1;
      BK_SHOW: begin
        if (!res_stall) begin
          pop = last_r;
          if (!last_r) begin
            idx_nxt = idx_r + CNT_W'(1);
          end
        end
      end
      default: ;
    endcase
  end

  assign rd_addr = {head.bank, ADDR_W'(PAY_START) + idx_nxt[ADDR_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_none) begin
      pay_r  <= '0;
      has_r  <= 1'b0;
      last_r <= 1'b1;
    end else if (load_pay) begin
      pay_r  <= rd_data;
      has_r  <= 1'b1;
      last_r <= (idx_r + CNT_W'(1)) == head.npay;
    end
  end

  assign res_valid         = state_r == BK_SHOW;
  assign res_status        = head.status;
  assign res_dest_pair     = head.dest_pair;
  assign res_source_pair   = head.source_pair;
  assign res_command_code  = head.command_code;
  assign res_payload_byte  = pay_r;
  assign res_has_payload   = has_r;
  assign res_last_of_frame = last_r;

endmodule

`default_nettype wire
